// ===== design/sbusfd_pkg.sv =====
// sbusfd_pkg: shared types and constants of the SBUS frame decoder.
// No dependencies; used by sbusfd_emit and sbus_frame_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none

package sbusfd_pkg;

    localparam int FRAME_LEN = 25;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam int CH_W      = 11;
    localparam int IDX_W     = 5;
    localparam int ERR_W     = 16;
    localparam int ACC_W     = 18;   // up to 10 leftover bits plus one byte
    localparam int BITS_W    = 5;

    localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FLAGS      = POS_W'(23);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_LEN - 1);

    localparam logic [CH_W-1:0] DIGITAL_HIGH = 11'd1811;
    localparam logic [CH_W-1:0] DIGITAL_LOW  = 11'd172;
    localparam logic [7:0]      FLAG_DIG1    = 8'h01;
    localparam logic [7:0]      FLAG_DIG2    = 8'h02;

    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    // result kinds
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    // configuration register indexes
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    // unpack sequencer steps; output index of step s (s >= 1) is s - 1
    localparam logic [IDX_W-1:0] STEP_CH0_HOLD = 5'd0;
    localparam logic [IDX_W-1:0] STEP_CH0_OUT  = 5'd3;
    localparam logic [IDX_W-1:0] STEP_DIG1     = 5'd17;
    localparam logic [IDX_W-1:0] STEP_DIG2     = 5'd18;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } buf_wr_t;

    typedef struct packed {
        logic             start;
        logic             bad;
        logic             bank;
        logic [ERR_W-1:0] err_total;
    } job_t;

endpackage

`default_nettype wire

// ===== design/sbusfd_emit.sv =====
// sbusfd_emit: two-bank frame buffer, 11-bit channel unpacker and result register.
// Depends on sbusfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbusfd_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sbusfd_pkg::buf_wr_t           wr,
    input  wire sbusfd_pkg::job_t              job,
    output logic                               busy,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [sbusfd_pkg::IDX_W-1:0]       m_channel_index,
    output logic [sbusfd_pkg::CH_W-1:0]        m_channel_value,
    output logic [sbusfd_pkg::ERR_W-1:0]       m_error_total,
    output logic                               m_last
);

    logic [7:0] mem_q [2][sbusfd_pkg::FRAME_LEN];

    logic                            busy_reg;
    logic                            bad_reg;
    logic                            bank_reg;
    logic [sbusfd_pkg::ERR_W-1:0]    err_reg;
    logic [sbusfd_pkg::POS_W-1:0]    rd_addr_reg;
    logic                            rd_valid_reg;
    logic [sbusfd_pkg::POS_W-1:0]    rd_idx_reg;
    logic [7:0]                      rd_data_reg;
    logic [sbusfd_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [sbusfd_pkg::BITS_W-1:0]   bits_reg, bits_next;
    logic [sbusfd_pkg::IDX_W-1:0]    step_reg;
    logic [sbusfd_pkg::CH_W-1:0]     chan0_reg;
    logic                            dig2_reg;

    logic                            m_valid_reg;
    logic                            m_kind_reg;
    logic [sbusfd_pkg::IDX_W-1:0]    m_idx_reg;
    logic [sbusfd_pkg::CH_W-1:0]     m_val_reg;
    logic [sbusfd_pkg::ERR_W-1:0]    m_err_reg;
    logic                            m_last_reg;

    logic                            out_free;
    logic                            acc_step;
    logic                            fire;
    logic                            fire_out;
    logic                            take_acc;
    logic [sbusfd_pkg::ACC_W-1:0]    acc_after;
    logic [sbusfd_pkg::BITS_W-1:0]   bits_after;
    logic                            consume_acc;
    logic                            consume;
    logic                            rd_en;
    logic                            issue;
    logic                            done;
    logic [sbusfd_pkg::CH_W-1:0]     out_val;
    logic                            have_ch;

    assign out_free = !m_valid_reg || m_ready;
    assign have_ch  = bits_reg >= sbusfd_pkg::BITS_W'(sbusfd_pkg::CH_W);
    // steps that pull an 11-bit field from the bit accumulator
    assign acc_step = (step_reg != sbusfd_pkg::STEP_CH0_OUT) &&
                      (step_reg <  sbusfd_pkg::STEP_DIG1);
    assign issue    = busy_reg && !bad_reg && (rd_addr_reg <= sbusfd_pkg::POS_FLAGS);

    always_comb begin
        fire    = 1'b0;
        out_val = '0;
        if (busy_reg && bad_reg) begin
            fire = out_free;
        end else if (busy_reg) begin
            case (step_reg)
                sbusfd_pkg::STEP_CH0_HOLD: begin
                    fire = have_ch;
                end
                sbusfd_pkg::STEP_CH0_OUT: begin
                    fire    = out_free;
                    out_val = chan0_reg;
                end
                sbusfd_pkg::STEP_DIG1: begin
                    fire    = out_free && rd_valid_reg && (rd_idx_reg == sbusfd_pkg::POS_FLAGS);
                    out_val = ((rd_data_reg & sbusfd_pkg::FLAG_DIG1) != 8'h00) ?
                              sbusfd_pkg::DIGITAL_HIGH : sbusfd_pkg::DIGITAL_LOW;
                end
                sbusfd_pkg::STEP_DIG2: begin
                    fire    = out_free;
                    out_val = dig2_reg ? sbusfd_pkg::DIGITAL_HIGH : sbusfd_pkg::DIGITAL_LOW;
                end
                default: begin
                    fire    = out_free && have_ch;
                    out_val = acc_reg[sbusfd_pkg::CH_W-1:0];
                end
            endcase
        end
    end

    assign fire_out = fire && (bad_reg || (step_reg != sbusfd_pkg::STEP_CH0_HOLD));
    assign done     = fire && (bad_reg || (step_reg == sbusfd_pkg::STEP_DIG2));
    assign take_acc = fire && !bad_reg && acc_step;

    assign acc_after  = take_acc ? (acc_reg >> sbusfd_pkg::CH_W) : acc_reg;
    assign bits_after = take_acc ? (bits_reg - sbusfd_pkg::BITS_W'(sbusfd_pkg::CH_W))
                                 : bits_reg;

    // channel bytes feed the accumulator; the flag byte waits for its step
    assign consume_acc = rd_valid_reg && (rd_idx_reg != sbusfd_pkg::POS_FLAGS) &&
                         (bits_after < sbusfd_pkg::BITS_W'(sbusfd_pkg::CH_W));
    assign consume     = consume_acc || (fire && !bad_reg && (step_reg == sbusfd_pkg::STEP_DIG1));
    assign rd_en       = !rd_valid_reg || consume;

    always_comb begin
        acc_next  = acc_after;
        bits_next = bits_after;
        if (consume_acc) begin
            acc_next  = acc_after | ({{(sbusfd_pkg::ACC_W-8){1'b0}}, rd_data_reg} << bits_after);
            bits_next = bits_after + sbusfd_pkg::BITS_W'(8);
        end
    end

    // frame buffer: capture writes one bank while the other is unpacked
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_q[wr.bank][wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_q[bank_reg][rd_addr_reg];
            rd_idx_reg  <= rd_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (job.start) begin
                busy_reg     <= 1'b1;
                rd_valid_reg <= 1'b0;
            end else begin
                if (done) begin
                    busy_reg <= 1'b0;
                end
                if (rd_en) begin
                    rd_valid_reg <= issue;
                end
            end
            if (fire_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job.start) begin
            bad_reg     <= job.bad;
            bank_reg    <= job.bank;
            err_reg     <= job.err_total;
            rd_addr_reg <= sbusfd_pkg::POS_FIRST_DATA;
            acc_reg     <= '0;
            bits_reg    <= '0;
            step_reg    <= sbusfd_pkg::STEP_CH0_HOLD;
        end else begin
            acc_reg  <= acc_next;
            bits_reg <= bits_next;
            if (rd_en && issue) begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            if (fire) begin
                step_reg <= step_reg + 1'b1;
            end
            if (fire && (step_reg == sbusfd_pkg::STEP_CH0_HOLD)) begin
                chan0_reg <= acc_reg[sbusfd_pkg::CH_W-1:0];
            end
            if (fire && (step_reg == sbusfd_pkg::STEP_DIG1)) begin
                dig2_reg <= (rd_data_reg & sbusfd_pkg::FLAG_DIG2) != 8'h00;
            end
        end
        if (fire_out) begin
            m_kind_reg <= bad_reg ? sbusfd_pkg::KIND_ERROR : sbusfd_pkg::KIND_CHANNEL;
            m_idx_reg  <= bad_reg ? '0 : (step_reg - 1'b1);
            m_val_reg  <= bad_reg ? '0 : out_val;
            m_err_reg  <= err_reg;
            m_last_reg <= done;
        end
    end

    assign busy            = busy_reg;
    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_channel_index = m_idx_reg;
    assign m_channel_value = m_val_reg;
    assign m_error_total   = m_err_reg;
    assign m_last          = m_last_reg;

    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (bits_reg <= sbusfd_pkg::BITS_W'(sbusfd_pkg::ACC_W)))
        else $error("accumulator bit count out of range");

    a_no_pull_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        consume |-> rd_valid_reg)
        else $error("byte consumed with no read data");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !job.start) |=> !busy_reg)
        else $error("unpacker still busy after final result");

endmodule

`default_nettype wire

// ===== design/sbus_frame_decoder_unit.sv =====
// sbus_frame_decoder_unit: SBUS receiver frame decoder, top level.
// Depends on sbusfd_pkg and sbusfd_emit.
//
//   port group   | dir | beat contents
//   -------------+-----+-------------------------------------------------
//   s_*          | in  | one received UART byte (s_rx_byte)
//   m_*          | out | one result: kind, channel index/value, error total, last
//   cfg_*        | in  | register write: 0 start marker, 1 end marker
//
// Rate: one input beat per cycle while s_ready is high. The unpacker emits 18 results
// for a good frame (11-bit fields unpacked from the single buffer read port) and one
// result for a bad one; two banks let the next frame fill meanwhile.
// Reset: synchronous, active low; markers to 15/0, capture state, bad-frame count.
// Stalls: s_ready drops at the last frame slot while the unpacker is still busy;
// m_ready low holds results and the unpacker.
`timescale 1ns / 1ps
`default_nettype none

module sbus_frame_decoder_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // byte input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_rx_byte,
    // result output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [sbusfd_pkg::IDX_W-1:0]       m_channel_index,
    output logic [sbusfd_pkg::CH_W-1:0]        m_channel_value,
    output logic [sbusfd_pkg::ERR_W-1:0]       m_error_total,
    output logic                               m_last,
    // configuration writes
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [7:0]                    cfg_wr_data
);

    logic [7:0]                      start_marker_reg;
    logic [7:0]                      end_marker_reg;
    logic [7:0]                      prev_byte_reg;
    logic                            capturing_reg;
    logic [sbusfd_pkg::POS_W-1:0]    pos_reg;
    logic [7:0]                      first_byte_reg;
    logic [sbusfd_pkg::ERR_W-1:0]    bad_count_reg, bad_count_next;
    logic                            cap_bank_reg;

    logic                            accept;
    logic                            restart;
    logic                            cap_eff;
    logic [sbusfd_pkg::POS_W-1:0]    pos_eff;
    logic                            store;
    logic                            frame_done;
    logic                            frame_good;
    logic [7:0]                      first_byte;
    logic                            emit_busy;

    sbusfd_pkg::buf_wr_t             wr;
    sbusfd_pkg::job_t                job;

    // Interlock: completing a frame needs a free unpacker. Only a beat at
    // the last frame slot can complete one (a restart always goes to slot 0).
    assign s_ready = !(emit_busy && capturing_reg && (pos_reg == sbusfd_pkg::POS_LAST));
    assign accept  = s_valid && s_ready;

    // start marker right after an end marker (re)opens a capture
    assign restart = (s_rx_byte == start_marker_reg) && (prev_byte_reg == end_marker_reg);
    assign cap_eff = restart || capturing_reg;
    assign pos_eff = restart ? '0 : pos_reg;
    assign store   = accept && cap_eff;

    assign frame_done = store && (pos_eff == sbusfd_pkg::POS_LAST);
    // markers are checked against the register values current at frame end
    assign first_byte = (pos_eff == '0) ? s_rx_byte : first_byte_reg;
    assign frame_good = (first_byte == start_marker_reg) && (s_rx_byte == end_marker_reg);

    // saturating bad-frame count
    always_comb begin
        bad_count_next = bad_count_reg;
        if (frame_done && !frame_good && (bad_count_reg != sbusfd_pkg::ERR_MAX)) begin
            bad_count_next = bad_count_reg + 1'b1;
        end
    end

    always_comb begin
        wr.en          = store;
        wr.bank        = cap_bank_reg;
        wr.addr        = pos_eff;
        wr.data        = s_rx_byte;
        job.start      = frame_done;
        job.bad        = !frame_good;
        job.bank       = cap_bank_reg;
        job.err_total  = bad_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= 8'd15;
            end_marker_reg   <= 8'd0;
            prev_byte_reg    <= '0;
            capturing_reg    <= 1'b0;
            pos_reg          <= '0;
            bad_count_reg    <= '0;
            cap_bank_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    sbusfd_pkg::REG_START_MARKER: start_marker_reg <= cfg_wr_data;
                    sbusfd_pkg::REG_END_MARKER:   end_marker_reg   <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (accept) begin
                prev_byte_reg <= s_rx_byte;
                if (cap_eff) begin
                    pos_reg       <= pos_eff + 1'b1;
                    capturing_reg <= !frame_done;
                end
            end
            if (frame_done) begin
                // hand the filled bank to the unpacker, fill the other one next
                cap_bank_reg <= !cap_bank_reg;
            end
            bad_count_reg <= bad_count_next;
        end
    end

    // payload: frame byte 0 for the start-marker check
    always_ff @(posedge aclk) begin
        if (store && (pos_eff == '0)) begin
            first_byte_reg <= s_rx_byte;
        end
    end

    sbusfd_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr              (wr),
        .job             (job),
        .busy            (emit_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_error_total   (m_error_total),
        .m_last          (m_last)
    );

    a_job_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |-> !emit_busy)
        else $error("frame completed while unpacker busy");

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        capturing_reg |-> (pos_reg <= sbusfd_pkg::POS_LAST))
        else $error("capture position past frame end");

    a_bank_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (cap_bank_reg != $past(cap_bank_reg)) && !capturing_reg)
        else $error("frame end did not swap banks and stop capture");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (bad_count_reg >= $past(bad_count_reg)))
        else $error("bad-frame count went down");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking testbench for sbus_frame_decoder_unit.
// Streams byte beats, predicts every result with a scoreboard class and checks
// each result beat in order. Depends on sbusfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CH_W           = sbusfd_pkg::CH_W;
    localparam int IDX_W          = sbusfd_pkg::IDX_W;
    localparam int ERR_W          = sbusfd_pkg::ERR_W;
    localparam int FRAME_BYTES    = 25;
    localparam int DATA_BYTES     = 22;   // bytes 1..22 hold the packed channels
    localparam int FLAG_BYTE      = 23;
    localparam int ANALOG_CHANS   = 16;
    localparam int NUM_OUTPUTS    = 18;
    localparam int SETTLE_CYCLES  = 40;   // margin after the last result beat
    localparam int MAX_REPORTS    = 10;
    localparam int SEGMENT_TARGET = 19;

    localparam logic [CH_W-1:0] SWITCH_ON  = 11'd1811;
    localparam logic [CH_W-1:0] SWITCH_OFF = 11'd172;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] chan_idx;
        logic [CH_W-1:0]  chan_val;
        logic [ERR_W-1:0] err_total;
        logic             is_last;
    } chan_result_t;

    // Tracks the decoder's capture state and holds the result beats owed by it.
    class frame_scoreboard;
        logic [7:0]       start_mark;
        logic [7:0]       end_mark;
        logic [7:0]       prev_byte;
        bit               in_frame;
        int               fill;
        logic [7:0]       frame_bytes [FRAME_BYTES];
        logic [ERR_W-1:0] bad_frames;
        chan_result_t     pending [$];
        int               failures;

        function new();
            start_mark = 8'd15;
            end_mark   = 8'd0;
            prev_byte  = 8'd0;
            in_frame   = 1'b0;
            fill       = 0;
            bad_frames = '0;
            failures   = 0;
        endfunction

        function void set_marker(logic idx, logic [7:0] value);
            if (idx == sbusfd_pkg::REG_START_MARKER) start_mark = value;
            else end_mark = value;
        endfunction

        function void decode_frame();
            logic [ANALOG_CHANS*CH_W-1:0] bit_stream;
            logic [CH_W-1:0]              chans [ANALOG_CHANS];
            chan_result_t                 r;
            // bytes 1..22 form one little-endian bit stream of 16 x 11-bit fields
            for (int i = 0; i < DATA_BYTES; i++) bit_stream[i*8 +: 8] = frame_bytes[i+1];
            for (int c = 0; c < ANALOG_CHANS; c++) chans[c] = bit_stream[c*CH_W +: CH_W];
            for (int o = 0; o < NUM_OUTPUTS; o++) begin
                r.kind      = sbusfd_pkg::KIND_CHANNEL;
                r.chan_idx  = IDX_W'(o);
                r.err_total = bad_frames;
                r.is_last   = (o == NUM_OUTPUTS - 1);
                case (o)
                    0:  r.chan_val = chans[1];
                    1:  r.chan_val = chans[2];
                    2:  r.chan_val = chans[0];
                    16: r.chan_val = frame_bytes[FLAG_BYTE][0] ? SWITCH_ON : SWITCH_OFF;
                    17: r.chan_val = frame_bytes[FLAG_BYTE][1] ? SWITCH_ON : SWITCH_OFF;
                    default: r.chan_val = chans[o];
                endcase
                pending.push_back(r);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            chan_result_t r;
            // start marker right after an end marker (re)opens a capture
            if (b == start_mark && prev_byte == end_mark) begin
                fill     = 0;
                in_frame = 1'b1;
            end
            if (in_frame) begin
                frame_bytes[fill] = b;
                fill++;
                if (fill == FRAME_BYTES) begin
                    in_frame = 1'b0;
                    // markers are judged against the registers as they are now
                    if (frame_bytes[0] == start_mark &&
                        frame_bytes[FRAME_BYTES-1] == end_mark) begin
                        decode_frame();
                    end else begin
                        if (bad_frames != '1) bad_frames++;
                        r.kind      = sbusfd_pkg::KIND_ERROR;
                        r.chan_idx  = '0;
                        r.chan_val  = '0;
                        r.err_total = bad_frames;
                        r.is_last   = 1'b1;
                        pending.push_back(r);
                    end
                end
            end
            prev_byte = b;
        endfunction

        function void check_result(chan_result_t got);
            chan_result_t want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result kind=%0d ch=%0d value=%0d errors=%0d last=%0d",
                             $time, got.kind, got.chan_idx, got.chan_val, got.err_total,
                             got.is_last);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: result mismatch: expected kind=%0d ch=%0d value=%0d",
                             $time, want.kind, want.chan_idx, want.chan_val);
                    $display("    expected errors=%0d last=%0d", want.err_total, want.is_last);
                    $display("    got kind=%0d ch=%0d value=%0d errors=%0d last=%0d",
                             got.kind, got.chan_idx, got.chan_val, got.err_total,
                             got.is_last);
                end
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_rx_byte;
    logic             m_valid;
    logic             m_ready;
    logic             m_kind;
    logic [IDX_W-1:0] m_channel_index;
    logic [CH_W-1:0]  m_channel_value;
    logic [ERR_W-1:0] m_error_total;
    logic             m_last;
    logic             cfg_wr_en;
    logic             cfg_addr;
    logic [7:0]       cfg_wr_data;

    frame_scoreboard  sb;
    logic [7:0]       byte_plan [$];
    logic [7:0]       plan_start;
    logic [7:0]       plan_end;
    int               tail_fill;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;

    sbus_frame_decoder_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_error_total   (m_error_total),
        .m_last          (m_last),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hang guard: a correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: ready toggles at the falling edge with the current idle rate.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_kind, m_channel_index, m_channel_value, m_error_total, m_last});
    end

    // Both marker registers in back-to-back write cycles; only called while idle.
    task automatic write_markers(input logic [7:0] start_v, input logic [7:0] end_v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= sbusfd_pkg::REG_START_MARKER;
        cfg_wr_data <= start_v;
        @(negedge aclk);
        cfg_addr    <= sbusfd_pkg::REG_END_MARKER;
        cfg_wr_data <= end_v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_marker(sbusfd_pkg::REG_START_MARKER, start_v);
        sb.set_marker(sbusfd_pkg::REG_END_MARKER, end_v);
        plan_start = start_v;
        plan_end   = end_v;
    endtask

    // One byte beat; random idle cycles ahead of it, valid held until accepted.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
    endtask

    task automatic send_plan();
        while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
    endtask

    // Sender holds off until every owed result is out, then the unpacker settles.
    task automatic drain_and_settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // payload bytes lean toward all-zero and all-one patterns
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] other_than(logic [7:0] v);
        logic [7:0] x;
        x = 8'($urandom_range(0, 255));
        if (x == v) x = v + 8'd1;
        return x;
    endfunction

    // end marker, start marker, 22 data bytes, flags, closing byte
    task automatic plan_frame(input bit good);
        byte_plan.push_back(plan_end);
        byte_plan.push_back(plan_start);
        repeat (DATA_BYTES + 1) byte_plan.push_back(payload_byte());
        byte_plan.push_back(good ? plan_end : other_than(plan_end));
    endtask

    // Mostly well-formed frames, some with a bad closing byte, some cut short
    // by a restart, some line noise. A segment may end inside a capture; the
    // next segment, under new markers, finishes that frame.
    task automatic build_segment(input int target);
        int pick;
        int k;
        if (tail_fill > 0) begin
            repeat (tail_fill - 1) byte_plan.push_back(payload_byte());
            byte_plan.push_back(plan_end);
            tail_fill = 0;
        end
        while (byte_plan.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                plan_frame(1'b1);
            end else if (pick == 6) begin
                plan_frame(1'b0);
            end else if (pick == 7) begin
                byte_plan.push_back(plan_end);
                byte_plan.push_back(plan_start);
                repeat ($urandom_range(1, 20)) byte_plan.push_back(payload_byte());
            end else begin
                repeat ($urandom_range(1, 4)) byte_plan.push_back(payload_byte());
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            k = $urandom_range(1, 20);
            byte_plan.push_back(plan_end);
            byte_plan.push_back(plan_start);
            repeat (k) byte_plan.push_back(payload_byte());
            tail_fill = FRAME_BYTES - 1 - k;
        end
    endtask

    initial begin
        s_valid       = 1'b0;
        s_rx_byte     = 8'h00;
        cfg_wr_en     = 1'b0;
        cfg_addr      = sbusfd_pkg::REG_START_MARKER;
        cfg_wr_data   = 8'h00;
        aresetn       = 1'b0;
        tail_fill     = 0;
        plan_start    = 8'h0F;
        plan_end      = 8'h00;
        send_idle_pct = 17;
        recv_idle_pct = 83;
        sb = new();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_markers(8'h0F, 8'h00);

        // Directed: a start marker with no end marker ahead of it is ignored,
        // a restart cuts a capture short, then a full-scale frame with only
        // the first digital switch set.
        byte_plan.push_back(8'hFF);
        byte_plan.push_back(8'h0F);
        byte_plan.push_back(8'h00);
        byte_plan.push_back(8'h0F);
        byte_plan.push_back(8'hA5);
        byte_plan.push_back(8'h00);
        byte_plan.push_back(8'h0F);
        repeat (DATA_BYTES) byte_plan.push_back(8'hFF);
        byte_plan.push_back(8'h01);
        byte_plan.push_back(8'h00);
        send_plan();
        drain_and_settle();

        // Random segments, each under its own marker setting and idle mix.
        for (int seg = 1; seg <= 5; seg++) begin
            case (seg)
                1:       write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                2:       write_markers(8'hFF, 8'h00);
                3:       write_markers(8'h00, 8'hFF);
                4:       write_markers(8'h5A, 8'h5A);   // equal markers
                default: write_markers(8'h0F, 8'h00);
            endcase
            if (seg <= 1) begin
                send_idle_pct = 17;
                recv_idle_pct = 83;
            end else if (seg <= 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            build_segment(SEGMENT_TARGET);
            send_plan();
            drain_and_settle();
        end

        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
